### rtl/core/ready_queue_with_removal_macros.svh
// Assertion macros shared by the ready queue checker.
`ifndef READY_QUEUE_WITH_REMOVAL_MACROS_SVH
`define READY_QUEUE_WITH_REMOVAL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RQR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ready queue check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RQR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ready queue check failed");

`endif

### rtl/core/rqr_pkg.sv
// Shared types, codes and defaults of the ready queue.
package rqr_pkg;

  // Default sizing
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  // Field widths
  localparam int KIND_W = 2;
  localparam int TID_W  = 8;
  localparam int STAT_W = 2;
  localparam int RID_W  = 8;
  localparam int CNT_W  = 5;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REM = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } rqr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } rqr_stat_t;

endpackage

### rtl/core/rqr_datapath.sv
// Queue storage, scan and compaction logic and result register.
module rqr_datapath #(
  parameter int DEPTH   = rqr_pkg::DEPTH_DEF,
  parameter int ID_BITS = rqr_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rqr_pkg::rqr_cmd_t            cmd,
  input  logic [rqr_pkg::KIND_W-1:0]   in_kind,
  input  logic [rqr_pkg::TID_W-1:0]    in_tid,
  output rqr_pkg::rqr_stat_t           stat,
  output logic [rqr_pkg::STAT_W-1:0]   res_status,
  output logic [rqr_pkg::RID_W-1:0]    res_id,
  output logic [rqr_pkg::CNT_W-1:0]    res_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = rqr_pkg::CNT_W;

  // Entry memory, index 0 is the head
  logic [ID_BITS-1:0] mem [DEPTH];

  logic [rqr_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [ID_BITS-1:0]         id_r, id_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]              pidx_r, pidx_nxt;
  logic                       pend_r, pend_nxt;
  logic                       found_r, found_nxt;
  logic [ID_BITS-1:0]         res_r, res_nxt;
  logic [ID_BITS-1:0]         rdata_r;
  logic [rqr_pkg::STAT_W-1:0] ostat_r, ostat_nxt;
  logic [rqr_pkg::RID_W-1:0]  orid_r, orid_nxt;
  logic [rqr_pkg::CNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ID_BITS-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [CW-1:0]      pidx_m1;
  logic [ID_BITS+7:0] tid_ext;
  logic [ID_BITS+7:0] res_ext;
  logic               more;

  // Fit the incoming identifier to the stored width
  assign tid_ext = {{ID_BITS{1'b0}}, in_tid};
  assign res_ext = {8'd0, res_r};
  assign pidx_m1 = pidx_r - CW'(1);
  assign more    = (rd_idx_r < count_r);
  assign raddr   = rd_idx_r[AW-1:0];

  assign stat.scan_done = !pend_r && !more;

  // Sequence loading, scanning, compaction and commit
  always_comb begin
    kind_nxt   = kind_r;
    id_nxt     = id_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    res_nxt    = res_r;
    ostat_nxt  = ostat_r;
    orid_nxt   = orid_r;
    ocnt_nxt   = ocnt_r;
    we         = 1'b0;
    waddr      = pidx_m1[AW-1:0];
    wdata      = rdata_r;

    if (cmd.load) begin
      kind_nxt   = in_kind;
      id_nxt     = tid_ext[ID_BITS-1:0];
      rd_idx_nxt = '0;
      pend_nxt   = 1'b0;
      found_nxt  = 1'b0;
      res_nxt    = '0;
    end

    if (cmd.scan) begin
      // Issue one read per cycle
      pend_nxt = 1'b0;
      if (more) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
        pidx_nxt   = rd_idx_r;
        pend_nxt   = 1'b1;
      end
      // Match the returned entry, or move it up by one after a match
      if (pend_r) begin
        if (!found_r) begin
          if (kind_r == rqr_pkg::KIND_DEQ || rdata_r == id_r) begin
            found_nxt = 1'b1;
            res_nxt   = rdata_r;
          end
        end else begin
          we = 1'b1;
        end
      end
    end

    if (cmd.finish) begin
      ostat_nxt = rqr_pkg::ST_OK;
      orid_nxt  = '0;
      unique case (kind_r)
        rqr_pkg::KIND_ENQ: begin
          if (count_r == CW'(DEPTH)) begin
            ostat_nxt = rqr_pkg::ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = count_r[AW-1:0];
            wdata     = id_r;
            count_nxt = count_r + CW'(1);
          end
        end
        rqr_pkg::KIND_DEQ: begin
          if (!found_r) begin
            ostat_nxt = rqr_pkg::ST_EMPTY;
          end else begin
            orid_nxt  = res_ext[7:0];
            count_nxt = count_r - CW'(1);
          end
        end
        rqr_pkg::KIND_REM: begin
          if (!found_r) begin
            ostat_nxt = rqr_pkg::ST_NOTFOUND;
          end else begin
            orid_nxt  = res_ext[7:0];
            count_nxt = count_r - CW'(1);
          end
        end
        rqr_pkg::KIND_NOP: begin
          ostat_nxt = rqr_pkg::ST_OK;
        end
        default: begin
          ostat_nxt = rqr_pkg::ST_OK;
        end
      endcase
      ocnt_nxt = OW'(count_nxt);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    id_r     <= id_nxt;
    rd_idx_r <= rd_idx_nxt;
    pidx_r   <= pidx_nxt;
    found_r  <= found_nxt;
    res_r    <= res_nxt;
    ostat_r  <= ostat_nxt;
    orid_r   <= orid_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign res_status = ostat_r;
  assign res_id     = orid_r;
  assign res_count  = ocnt_r;

endmodule

### rtl/core/rqr_ctrl.sv
// Controller state machine of the ready queue and its handshakes.
module rqr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rqr_pkg::KIND_W-1:0] in_kind,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  rqr_pkg::rqr_stat_t         stat,
  output rqr_pkg::rqr_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  // Step through accept, scan and commit
  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_kind == rqr_pkg::KIND_DEQ || in_kind == rqr_pkg::KIND_REM) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Commit only once the result register is free
        if (!ovalid_r || out_tready) begin
          cmd.finish = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

### rtl/core/ready_queue_with_removal.sv
// Top level of the ready queue: controller plus datapath.
// Ready queue of thread identifiers with removal by identifier.
// Input channel in_*: in_tuser carries the operation (enqueue at tail,
// dequeue head, remove first match, or ignored code), in_tdata the thread
// identifier. Each accepted item yields exactly one result on out_*:
// status, identifier taken out and entry count after the operation.
// One item is worked on at a time; in_tready is high only while idle.
// Enqueue and the ignored code skip the scan and go from accept straight
// to commit.
// Dequeue and remove walk the held entries through a single memory read
// port, one entry per cycle, comparing and moving later entries up by one
// in the same pass, then commit.
// A result waits in the output register while out_tready is low; the next
// item may already be accepted, and its commit holds until the register
// is taken. Reset empties the queue at once (no clearing pass) and drops
// any pending result.
module ready_queue_with_removal #(
  parameter int DEPTH   = rqr_pkg::DEPTH_DEF,
  parameter int ID_BITS = rqr_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] thread_id
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [9:2] result_id, [14:10] count, [15] zero
);

  rqr_pkg::rqr_cmd_t             cmd;
  rqr_pkg::rqr_stat_t            stat;
  logic [rqr_pkg::STAT_W-1:0]    res_status;
  logic [rqr_pkg::RID_W-1:0]     res_id;
  logic [rqr_pkg::CNT_W-1:0]     res_count;

  rqr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rqr_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_tuser),
    .in_tid     (in_tdata),
    .stat       (stat),
    .res_status (res_status),
    .res_id     (res_id),
    .res_count  (res_count)
  );

  // Pack the result fields, status in the lowest bits
  assign out_tdata = {1'b0, res_count, res_id, res_status};

endmodule

### rtl/core/rqr_checker.sv
// Port-level checker of the ready queue and its bind.
`include "ready_queue_with_removal_macros.svh"

module rqr_checker #(
  parameter int DEPTH = rqr_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Hold a stalled result
  `RQR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Take one item at a time
  `RQR_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready)
  // Report no identifier on a failed operation
  `RQR_ASSERT_IMP(a_rid_zero, out_tvalid && out_tdata[1:0] != rqr_pkg::ST_OK, out_tdata[9:2] == 8'd0)
  // Flag full only at the depth
  `RQR_ASSERT_IMP(a_full_cnt, out_tvalid && out_tdata[1:0] == rqr_pkg::ST_FULL, out_tdata[14:10] == 5'(DEPTH))
  // Flag empty only with no entries
  `RQR_ASSERT_IMP(a_empty_cnt, out_tvalid && out_tdata[1:0] == rqr_pkg::ST_EMPTY, out_tdata[14:10] == 5'd0)

endmodule

bind ready_queue_with_removal rqr_checker #(
  .DEPTH (DEPTH)
) u_rqr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
